>>> rtl/rcwf_pkg.sv
// ----------------------------------------------------------------------------
// rcwf_pkg
// Shared types and constants for the RGB colour wheel fade controller.
// ----------------------------------------------------------------------------
package rcwf_pkg;

    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_WHEEL  = 2'd1,
        MODE_STEADY = 2'd2,
        MODE_APP    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_PERIOD  = 3'd0,
        REG_PHASE_LENGTH = 3'd1,
        REG_APP_RED      = 3'd2,
        REG_APP_GREEN    = 3'd3,
        REG_APP_BLUE     = 3'd4
    } cfg_reg_t;

    // fade phases: which channel moves and in which direction
    localparam logic [PHASE_W-1:0] PH_GREEN_UP   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RED_DOWN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BLUE_UP    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_GREEN_DOWN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RED_UP     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_BLUE_DOWN  = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_COUNT   = 3'd6;

    localparam logic [LEVEL_W-1:0] WHEEL_RED   = 8'd251;
    localparam logic [LEVEL_W-1:0] WHEEL_GREEN = 8'd1;
    localparam logic [LEVEL_W-1:0] WHEEL_BLUE  = 8'd1;

    localparam logic [COUNT_W-1:0] HALF_PERIOD_RST  = 8'd2;
    localparam logic [COUNT_W-1:0] PHASE_LENGTH_RST = 8'd250;

    typedef struct packed {
        logic [COUNT_W-1:0] half_period;
        logic [COUNT_W-1:0] phase_length;
        logic [LEVEL_W-1:0] app_red;
        logic [LEVEL_W-1:0] app_green;
        logic [LEVEL_W-1:0] app_blue;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic               lit;
    } colour_t;

endpackage

>>> rtl/rcwf_in_if.sv
// ----------------------------------------------------------------------------
// rcwf_in_if
// Command channel: tick or set-mode word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcwf_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] mode;

    modport source (output valid, output cmd, output mode, input ready);
    modport sink   (input valid, input cmd, input mode, output ready);
endinterface

>>> rtl/rcwf_out_if.sv
// ----------------------------------------------------------------------------
// rcwf_out_if
// Result channel: current colour and lit flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcwf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       lit;

    modport source (output valid, output red, output green, output blue, output lit,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input lit,
                    output ready);
endinterface

>>> rtl/rgb_color_wheel_fade.sv
// A result word is valid in the cycle after its command word is accepted.
// Throughput: one word per cycle while result ready is high; the single output register
// reloads in the cycle its word is taken, so input ready follows output ready.
// Reset (rst_n low, async): display off, colour zero, counters clear,
// half period 2, phase length 250, app colour zero; no word pending.
// ----------------------------------------------------------------------------
// rgb_color_wheel_fade
// RGB LED mode controller with a six-phase colour wheel fade.
// ----------------------------------------------------------------------------
module rgb_color_wheel_fade (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rcwf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcwf_pkg::CFG_DAT_W-1:0]  cfg_data,
    rcwf_in_if.sink                         item,
    rcwf_out_if.source                      result
);

    rcwf_pkg::cfg_t     cfg;
    rcwf_pkg::colour_t  colour_next;
    logic               can_load;
    logic               accept;

    assign item.ready = can_load;
    assign accept     = item.valid && can_load;

    rcwf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcwf_fade_core u_fade_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (item.cmd),
        .mode        (item.mode),
        .cfg         (cfg),
        .colour_next (colour_next)
    );

    rcwf_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .colour_next (colour_next),
        .can_load    (can_load),
        .result      (result)
    );

endmodule

>>> rtl/rcwf_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcwf_cfg_regs
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module rcwf_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rcwf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcwf_pkg::CFG_DAT_W-1:0]  cfg_data,
    output rcwf_pkg::cfg_t                  cfg
);

    rcwf_pkg::cfg_t cfg_reg;
    rcwf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (rcwf_pkg::cfg_reg_t'(cfg_index))
                rcwf_pkg::REG_HALF_PERIOD:  cfg_next.half_period  = cfg_data;
                rcwf_pkg::REG_PHASE_LENGTH: cfg_next.phase_length = cfg_data;
                rcwf_pkg::REG_APP_RED:      cfg_next.app_red      = cfg_data;
                rcwf_pkg::REG_APP_GREEN:    cfg_next.app_green    = cfg_data;
                rcwf_pkg::REG_APP_BLUE:     cfg_next.app_blue     = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period  <= rcwf_pkg::HALF_PERIOD_RST;
            cfg_reg.phase_length <= rcwf_pkg::PHASE_LENGTH_RST;
            cfg_reg.app_red      <= '0;
            cfg_reg.app_green    <= '0;
            cfg_reg.app_blue     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/rcwf_fade_core.sv
// ----------------------------------------------------------------------------
// rcwf_fade_core
// Mode and fade state; works out the next colour for each accepted word.
// ----------------------------------------------------------------------------
module rcwf_fade_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               cmd,
    input  logic [1:0]         mode,
    input  rcwf_pkg::cfg_t     cfg,
    output rcwf_pkg::colour_t  colour_next
);

    rcwf_pkg::mode_t                    mode_reg, mode_next;
    logic [rcwf_pkg::COUNT_W-1:0]       tick_reg, tick_next;
    logic [rcwf_pkg::COUNT_W-1:0]       step_reg, step_next;
    logic [rcwf_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [rcwf_pkg::LEVEL_W-1:0]       red_reg, red_next;
    logic [rcwf_pkg::LEVEL_W-1:0]       green_reg, green_next;
    logic [rcwf_pkg::LEVEL_W-1:0]       blue_reg, blue_next;
    logic                               fade_en_reg, fade_en_next;

    logic [rcwf_pkg::COUNT_W-1:0]       tick_inc;
    logic [rcwf_pkg::COUNT_W-1:0]       step_inc;
    logic [rcwf_pkg::PHASE_W-1:0]       phase_inc;
    logic [rcwf_pkg::PHASE_W-1:0]       phase_step;
    logic [rcwf_pkg::COUNT_W-1:0]       step_step;

    assign tick_inc  = tick_reg + 1'b1;
    assign step_inc  = step_reg + 1'b1;
    assign phase_inc = (phase_reg + 1'b1 >= rcwf_pkg::PHASE_COUNT) ? '0 : phase_reg + 1'b1;

    // step counter and phase after one fade step
    always_comb
    begin
        if (step_inc >= cfg.phase_length)
        begin
            step_step  = '0;
            phase_step = phase_inc;
        end
        else
        begin
            step_step  = step_inc;
            phase_step = phase_reg;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        tick_next    = tick_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        fade_en_next = fade_en_reg;

        if (accept && cmd)
        begin
            mode_next = rcwf_pkg::mode_t'(mode);
            tick_next = '0;
            case (rcwf_pkg::mode_t'(mode))
                rcwf_pkg::MODE_OFF:
                begin
                    fade_en_next = 1'b0;
                    red_next     = '0;
                    green_next   = '0;
                    blue_next    = '0;
                end
                rcwf_pkg::MODE_WHEEL:
                begin
                    fade_en_next = 1'b1;
                    red_next     = rcwf_pkg::WHEEL_RED;
                    green_next   = rcwf_pkg::WHEEL_GREEN;
                    blue_next    = rcwf_pkg::WHEEL_BLUE;
                    step_next    = '0;
                    phase_next   = '0;
                end
                rcwf_pkg::MODE_STEADY:
                begin
                    fade_en_next = 1'b0;
                end
                default:
                begin
                    fade_en_next = 1'b0;
                    red_next     = cfg.app_red;
                    green_next   = cfg.app_green;
                    blue_next    = cfg.app_blue;
                end
            endcase
        end
        else if (accept)
        begin
            if (!fade_en_reg)
            begin
                tick_next = '0;
            end
            else if (tick_inc >= cfg.half_period)
            begin
                tick_next  = '0;
                step_next  = step_step;
                phase_next = phase_step;
                case (phase_step)
                    rcwf_pkg::PH_GREEN_UP:   green_next = green_reg + 1'b1;
                    rcwf_pkg::PH_RED_DOWN:   red_next   = red_reg - 1'b1;
                    rcwf_pkg::PH_BLUE_UP:    blue_next  = blue_reg + 1'b1;
                    rcwf_pkg::PH_GREEN_DOWN: green_next = green_reg - 1'b1;
                    rcwf_pkg::PH_RED_UP:     red_next   = red_reg + 1'b1;
                    rcwf_pkg::PH_BLUE_DOWN:  blue_next  = blue_reg - 1'b1;
                    default:                 red_next   = red_reg;
                endcase
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rcwf_pkg::MODE_OFF;
            tick_reg    <= '0;
            step_reg    <= '0;
            phase_reg   <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
            fade_en_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            tick_reg    <= tick_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            fade_en_reg <= fade_en_next;
        end
    end

    assign colour_next.red   = red_next;
    assign colour_next.green = green_next;
    assign colour_next.blue  = blue_next;
    assign colour_next.lit   = (mode_next != rcwf_pkg::MODE_OFF);

    // phase counter never leaves the six-phase range
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < rcwf_pkg::PHASE_COUNT)
        else $error("fade phase out of range");

    // tick counter only runs while fading
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fade_en_reg |-> tick_reg == '0)
        else $error("tick counter running with fade disabled");

    // fading only in wheel mode
    a_fade_mode: assert property (@(posedge clk) disable iff (!rst_n)
        fade_en_reg |-> mode_reg == rcwf_pkg::MODE_WHEEL)
        else $error("fade enabled outside wheel mode");

    // off mode keeps the LEDs dark
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == rcwf_pkg::MODE_OFF |-> (red_reg == '0 && green_reg == '0
                                            && blue_reg == '0))
        else $error("colour not zero in off mode");

endmodule

>>> rtl/rcwf_out_stage.sv
// ----------------------------------------------------------------------------
// rcwf_out_stage
// Result register; reloads in the cycle it is drained.
// ----------------------------------------------------------------------------
module rcwf_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  rcwf_pkg::colour_t  colour_next,
    output logic               can_load,
    rcwf_out_if.source         result
);

    logic               valid_reg, valid_next;
    rcwf_pkg::colour_t  colour_reg;

    assign can_load   = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            colour_reg <= colour_next;
        end
    end

    assign result.valid = valid_reg;
    assign result.red   = colour_reg.red;
    assign result.green = colour_reg.green;
    assign result.blue  = colour_reg.blue;
    assign result.lit   = colour_reg.lit;

    // a loaded word is presented in the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded word not presented");

    // never load over a word that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result word overwritten");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB colour wheel fade controller. A scoreboard
// class tracks mode, fade counters and channel levels for every command word
// taken and checks each colour word against it, in order. A directed opening
// is followed by randomised phases under several register settings and
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import rcwf_pkg::*;

    localparam int  CLK_HALF      = 4;
    localparam int  RESET_CYCLES  = 7;
    localparam int  SETTLE_CYCLES = 3;
    localparam int  CYCLE_LIMIT   = 200000;
    localparam int  REPORT_MAX    = 10;
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SET_MODE = 1'b1;

    // ------------------------------------------------------------------
    // scoreboard: follows the controller state and holds expected colours
    // ------------------------------------------------------------------
    class wheel_scoreboard;
        logic [COUNT_W-1:0] half_period;
        logic [COUNT_W-1:0] phase_length;
        logic [LEVEL_W-1:0] app_red;
        logic [LEVEL_W-1:0] app_green;
        logic [LEVEL_W-1:0] app_blue;
        mode_t              display_mode;
        logic [COUNT_W-1:0] tick_count;
        logic [COUNT_W-1:0] step_count;
        logic [PHASE_W-1:0] phase;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        bit                 fading;
        colour_t            pending_colours[$];
        int unsigned        mismatches;

        function new();
            half_period  = HALF_PERIOD_RST;
            phase_length = PHASE_LENGTH_RST;
            app_red      = '0;
            app_green    = '0;
            app_blue     = '0;
            display_mode = MODE_OFF;
            tick_count   = '0;
            step_count   = '0;
            phase        = '0;
            red          = '0;
            green        = '0;
            blue         = '0;
            fading       = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
            case (idx)
                REG_HALF_PERIOD:  half_period  = value;
                REG_PHASE_LENGTH: phase_length = value;
                REG_APP_RED:      app_red      = value;
                REG_APP_GREEN:    app_green    = value;
                REG_APP_BLUE:     app_blue     = value;
                default: ;
            endcase
        endfunction

        function void fade_step();
            step_count = step_count + 1'b1;
            if (step_count >= phase_length)
            begin
                step_count = '0;
                phase      = phase + 1'b1;
                if (phase >= PHASE_COUNT)
                    phase = '0;
            end
            case (phase)
                PH_GREEN_UP:   green = green + 1'b1;
                PH_RED_DOWN:   red   = red - 1'b1;
                PH_BLUE_UP:    blue  = blue + 1'b1;
                PH_GREEN_DOWN: green = green - 1'b1;
                PH_RED_UP:     red   = red + 1'b1;
                PH_BLUE_DOWN:  blue  = blue - 1'b1;
                default: ;
            endcase
        endfunction

        function void note_word(logic cmd, logic [1:0] mode);
            colour_t expected;
            if (cmd == CMD_SET_MODE)
            begin
                display_mode = mode_t'(mode);
                case (display_mode)
                    MODE_OFF:
                    begin
                        fading = 1'b0;
                        red    = '0;
                        green  = '0;
                        blue   = '0;
                    end
                    MODE_WHEEL:
                    begin
                        fading     = 1'b1;
                        red        = WHEEL_RED;
                        green      = WHEEL_GREEN;
                        blue       = WHEEL_BLUE;
                        step_count = '0;
                        phase      = '0;
                    end
                    MODE_STEADY:
                        fading = 1'b0;
                    default:
                    begin
                        fading = 1'b0;
                        red    = app_red;
                        green  = app_green;
                        blue   = app_blue;
                    end
                endcase
                tick_count = '0;
            end
            else if (fading)
            begin
                tick_count = tick_count + 1'b1;
                if (tick_count >= half_period)
                begin
                    fade_step();
                    tick_count = '0;
                end
            end
            else
                tick_count = '0;
            expected.red   = red;
            expected.green = green;
            expected.blue  = blue;
            expected.lit   = (display_mode != MODE_OFF);
            pending_colours.push_back(expected);
        endfunction

        function void check_colour(colour_t got);
            colour_t expected;
            if (pending_colours.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected colour word r=%0d g=%0d b=%0d lit=%0b",
                             got.red, got.green, got.blue, got.lit);
                return;
            end
            expected = pending_colours.pop_front();
            if (got.red !== expected.red || got.green !== expected.green ||
                got.blue !== expected.blue || got.lit !== expected.lit)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("colour mismatch at %0t: expected r=%0d g=%0d b=%0d lit=%0b, got r=%0d g=%0d b=%0d lit=%0b",
                             $realtime, expected.red, expected.green, expected.blue,
                             expected.lit, got.red, got.green, got.blue, got.lit);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    int                   sender_idle_pct;
    int                   receiver_stall_pct;
    int unsigned          cycle_count;
    wheel_scoreboard      board;

    rcwf_in_if  item_if ();
    rcwf_out_if result_if ();

    rgb_color_wheel_fade u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side: check taken words, then pick ready for the next edge
    initial
    begin
        colour_t got;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            begin
                got.red   = result_if.red;
                got.green = result_if.green;
                got.blue  = result_if.blue;
                got.lit   = result_if.lit;
                board.check_colour(got);
            end
            result_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // valid stays high between back-to-back words; dropped while idling or draining
    task automatic send_word(input logic cmd, input logic [1:0] mode);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.cmd   <= cmd;
        item_if.mode  <= mode;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        board.note_word(cmd, mode);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (board.pending_colours.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] hp, input logic [7:0] pl,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
        cfg_reg_t        idx [5];
        logic [7:0]      val [5];
        idx = '{REG_HALF_PERIOD, REG_PHASE_LENGTH, REG_APP_RED, REG_APP_GREEN,
                REG_APP_BLUE};
        val = '{hp, pl, r, g, b};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            board.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly ticks on a running wheel; mode_pct sets how often a mode word lands
    task automatic run_phase(input logic [7:0] hp, input logic [7:0] pl,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input int idle_pct,
                             input int stall_pct, input int n_words,
                             input int mode_pct);
        int roll;
        wait_drained();
        program_regs(hp, pl, r, g, b);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        send_word(CMD_SET_MODE, MODE_WHEEL);
        for (int i = 1; i < n_words; i++)
        begin
            if (i == n_words / 2)
                wait_drained();
            roll = $urandom_range(99);
            if (roll < mode_pct / 2)
                send_word(CMD_SET_MODE, MODE_WHEEL);
            else if (roll < mode_pct)
                send_word(CMD_SET_MODE, 2'($urandom_range(3)));
            else
                send_word(CMD_TICK, 2'($urandom_range(3)));
        end
    endtask

    initial
    begin
        board              = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_HALF_PERIOD;
        cfg_data       <= '0;
        item_if.valid  <= 1'b0;
        item_if.cmd    <= CMD_TICK;
        item_if.mode   <= MODE_OFF;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening on the reset register values
        send_word(CMD_TICK, MODE_OFF);
        send_word(CMD_TICK, MODE_APP);
        send_word(CMD_SET_MODE, MODE_STEADY);
        send_word(CMD_SET_MODE, MODE_APP);
        send_word(CMD_SET_MODE, MODE_WHEEL);
        repeat (6) send_word(CMD_TICK, MODE_OFF);
        send_word(CMD_SET_MODE, MODE_STEADY);
        send_word(CMD_TICK, MODE_WHEEL);
        send_word(CMD_SET_MODE, MODE_WHEEL);
        send_word(CMD_TICK, MODE_STEADY);
        send_word(CMD_TICK, MODE_APP);
        send_word(CMD_SET_MODE, MODE_APP);
        send_word(CMD_TICK, MODE_WHEEL);
        send_word(CMD_SET_MODE, MODE_OFF);
        send_word(CMD_TICK, MODE_OFF);
        send_word(CMD_SET_MODE, MODE_OFF);

        // short settings; at zero half period / zero phase length a step and a phase move on every tick
        run_phase(8'd1, 8'd3, 8'hFF, 8'h00, 8'hFF, 0, 0, 200, 6);
        run_phase(8'd0, 8'd0, 8'h00, 8'hFF, 8'h00, 81, 0, 200, 6);
        run_phase(8'd3, 8'd5, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 0, 81, 180, 6);
        // long phases, where red is driven down past zero and wraps, then a long half period
        run_phase(8'd0, 8'd255, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 34, 34, 700, 0);
        run_phase(8'd255, 8'd1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 0, 0, 300, 0);

        wait_drained();
        if (board.pending_colours.size() != 0)
            board.mismatches++;
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
